// ----- hdl/hbat_pkg.sv -----
package hbat_pkg;

    localparam int SLOTS_DEF = 64;
    localparam int CAP_W     = 7;
    localparam int THR_W     = 3;
    localparam int ID_W      = 32;
    localparam int PC_W      = 48;
    localparam int KIND_W    = 3;
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 24;
    localparam int CNT_MAX   = 127;

    localparam logic [CAP_W-1:0] CAP_RST = CAP_W'(32);

    localparam logic [KIND_W-1:0] KIND_ADD      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RESOLVE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_COMMIT   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SQ_AFTER = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SQ_TGT   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLR_THR  = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic             resolved;
        logic             admitted;
        logic [THR_W-1:0] thread;
        logic [ID_W-1:0]  target;
        logic [PC_W-1:0]  address;
    } t_entry;

    typedef struct packed {
        logic thr_eq;
        logic tgt_eq;
        logic tgt_gt;
        logic addr_eq;
        logic key_eq;
    } t_match;

endpackage

// ----- hdl/hbat_slot_mem.sv -----
module hbat_slot_mem #(
    parameter int DEPTH = hbat_pkg::SLOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  hbat_pkg::t_entry         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output hbat_pkg::t_entry         o_rdata
);
    import hbat_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/hbat_match.sv -----
module hbat_match (
    input  hbat_pkg::t_entry                i_entry,
    input  logic [hbat_pkg::THR_W-1:0]      i_thread,
    input  logic [hbat_pkg::ID_W-1:0]       i_id,
    input  logic [hbat_pkg::PC_W-1:0]       i_pc,
    output hbat_pkg::t_match                o_match
);
    import hbat_pkg::*;

    always_comb begin
        o_match.thr_eq  = (i_entry.thread == i_thread);
        o_match.tgt_eq  = (i_entry.target == i_id);
        o_match.tgt_gt  = (i_entry.target > i_id);
        o_match.addr_eq = (i_entry.address == i_pc);
        o_match.key_eq  = o_match.thr_eq && o_match.tgt_eq && o_match.addr_eq;
    end

endmodule

// ----- hdl/hard_branch_admission_table.sv -----
// Admission table for hard-to-predict branches, keyed by thread, fetch-target id
// and pc. Each operation arrives as one slave transaction (kind in tuser) and
// yields exactly one master transaction. Operations of kind 0..5 sweep the whole
// slot store through its single read port, one slot per cycle, sharing one key
// comparator, then apply the update in the finish state, which waits while the
// previous result still sits unaccepted in the output register; unused kinds 6
// and 7 skip the sweep. The slave side is ready only between operations; a finished result
// waits in the output register while the next operation is already accepted.
// Capacity may be written at any time the block is idle; its channel is always
// ready. No clearing pass is needed after reset.
module hard_branch_admission_table #(
    parameter int TABLE_SLOTS = hbat_pkg::SLOTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // thread[2:0], ftq_id[34:3], pc[82:35], zero fill
    input  logic [hbat_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // kind[2:0]
    input  logic [hbat_pkg::KIND_W-1:0]      i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // found[0], admitted[1], rejected[2], removed_count[9:3], store_full[10],
    // peak_occupancy[17:11], zero fill
    output logic [hbat_pkg::M_TDATA_W-1:0]   o_m_tdata,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [hbat_pkg::CAP_W-1:0]       i_cfg_data
);
    import hbat_pkg::*;

    localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CW = $clog2(TABLE_SLOTS + 1);

    t_state                 r_state, n_state;
    logic [TABLE_SLOTS-1:0] r_valid, n_valid;
    logic [CAP_W-1:0]       r_cap, n_cap;
    logic [CAP_W-1:0]       r_tot, n_tot;
    logic [CAP_W-1:0]       r_peak, n_peak;
    logic [KIND_W-1:0]      r_kind, n_kind;
    logic [THR_W-1:0]       r_thr, n_thr;
    logic [ID_W-1:0]        r_id, n_id;
    logic [PC_W-1:0]        r_pc, n_pc;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_ev_vld, n_ev_vld;
    logic [IW-1:0]          r_ev_idx, n_ev_idx;
    logic                   r_p_fnd, n_p_fnd;
    logic [IW-1:0]          r_p_idx, n_p_idx;
    logic                   r_p_adm, n_p_adm;
    logic                   r_r_fnd, n_r_fnd;
    logic                   r_r_adm, n_r_adm;
    logic [IW-1:0]          r_r_idx, n_r_idx;
    logic                   r_f_fnd, n_f_fnd;
    logic [IW-1:0]          r_f_idx, n_f_idx;
    logic [CW-1:0]          r_removed, n_removed;
    logic                   r_out_vld, n_out_vld;
    logic [M_TDATA_W-1:0]   r_out_data, n_out_data;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic [IW-1:0] mem_raddr;
    t_entry        rd_entry;
    t_match        mt;

    hbat_slot_mem #(
        .DEPTH (TABLE_SLOTS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rd_entry)
    );

    hbat_match u_match (
        .i_entry  (rd_entry),
        .i_thread (r_thr),
        .i_id     (r_id),
        .i_pc     (r_pc),
        .o_match  (mt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= '0;
            r_cap     <= CAP_RST;
            r_tot     <= '0;
            r_peak    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_cap     <= n_cap;
            r_tot     <= n_tot;
            r_peak    <= n_peak;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_thr      <= n_thr;
        r_id       <= n_id;
        r_pc       <= n_pc;
        r_cnt      <= n_cnt;
        r_ev_vld   <= n_ev_vld;
        r_ev_idx   <= n_ev_idx;
        r_p_fnd    <= n_p_fnd;
        r_p_idx    <= n_p_idx;
        r_p_adm    <= n_p_adm;
        r_r_fnd    <= n_r_fnd;
        r_r_adm    <= n_r_adm;
        r_r_idx    <= n_r_idx;
        r_f_fnd    <= n_f_fnd;
        r_f_idx    <= n_f_idx;
        r_removed  <= n_removed;
        r_out_data <= n_out_data;
    end

    always_comb begin
        logic             v;
        logic             hit;
        logic             ok;
        logic             found;
        logic             adm;
        logic             rej;
        logic             full;
        logic [CAP_W-1:0] rem_sat;

        n_state    = r_state;
        n_valid    = r_valid;
        n_cap      = r_cap;
        n_tot      = r_tot;
        n_peak     = r_peak;
        n_kind     = r_kind;
        n_thr      = r_thr;
        n_id       = r_id;
        n_pc       = r_pc;
        n_cnt      = r_cnt;
        n_ev_vld   = 1'b0;
        n_ev_idx   = r_ev_idx;
        n_p_fnd    = r_p_fnd;
        n_p_idx    = r_p_idx;
        n_p_adm    = r_p_adm;
        n_r_fnd    = r_r_fnd;
        n_r_adm    = r_r_adm;
        n_r_idx    = r_r_idx;
        n_f_fnd    = r_f_fnd;
        n_f_idx    = r_f_idx;
        n_removed  = r_removed;
        n_out_vld  = r_out_vld;
        n_out_data = r_out_data;
        mem_we     = 1'b0;
        mem_waddr  = r_f_idx;
        mem_wdata  = '{resolved: 1'b0, admitted: 1'b0, thread: r_thr,
                       target: r_id, address: r_pc};
        mem_raddr  = r_cnt[IW-1:0];
        v          = r_valid[r_ev_idx];
        hit        = 1'b0;
        ok         = 1'b0;
        found      = 1'b0;
        adm        = 1'b0;
        rej        = 1'b0;
        full       = 1'b0;
        rem_sat    = (32'(r_removed) > 32'(CNT_MAX)) ? CAP_W'(CNT_MAX)
                                                     : CAP_W'(r_removed);

        if (i_cfg_valid) begin
            n_cap = i_cfg_data;
        end

        if (r_out_vld && i_m_tready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_kind    = i_s_tuser;
                    n_thr     = i_s_tdata[THR_W-1:0];
                    n_id      = i_s_tdata[THR_W +: ID_W];
                    n_pc      = i_s_tdata[THR_W+ID_W +: PC_W];
                    n_cnt     = '0;
                    n_p_fnd   = 1'b0;
                    n_r_fnd   = 1'b0;
                    n_f_fnd   = 1'b0;
                    n_removed = '0;
                    n_state   = (i_s_tuser <= KIND_CLR_THR) ? ST_SWEEP : ST_FINISH;
                end
            end
            ST_SWEEP: begin
                n_ev_vld = (r_cnt < CW'(TABLE_SLOTS));
                n_ev_idx = r_cnt[IW-1:0];
                n_cnt    = r_cnt + CW'(1);
                if (r_cnt == CW'(TABLE_SLOTS)) begin
                    n_state = ST_FINISH;
                end
                if (r_ev_vld) begin
                    if (v && !rd_entry.resolved && mt.key_eq && !r_p_fnd) begin
                        n_p_fnd = 1'b1;
                        n_p_idx = r_ev_idx;
                        n_p_adm = rd_entry.admitted;
                    end
                    if (v && rd_entry.resolved && mt.key_eq && !r_r_fnd) begin
                        n_r_fnd = 1'b1;
                        n_r_idx = r_ev_idx;
                        n_r_adm = rd_entry.admitted;
                    end
                    if (!v && !r_f_fnd) begin
                        n_f_fnd = 1'b1;
                        n_f_idx = r_ev_idx;
                    end
                    case (r_kind)
                        KIND_SQ_AFTER: hit = mt.tgt_gt;
                        KIND_SQ_TGT:   hit = mt.tgt_eq && !mt.addr_eq;
                        KIND_CLR_THR:  hit = 1'b1;
                        default:       hit = 1'b0;
                    endcase
                    if (v && mt.thr_eq && hit) begin
                        n_valid[r_ev_idx] = 1'b0;
                        if (!rd_entry.resolved && rd_entry.admitted) begin
                            n_removed = r_removed + CW'(1);
                            if (r_tot != '0) begin
                                n_tot = r_tot - CAP_W'(1);
                            end
                        end
                    end
                end
            end
            ST_FINISH: begin
                if (!(r_out_vld && !i_m_tready)) begin
                    unique case (r_kind)
                        KIND_ADD: begin
                            if (!r_p_fnd) begin
                                if (!r_f_fnd) begin
                                    full = 1'b1;
                                end else begin
                                    ok                 = (r_tot < r_cap);
                                    mem_we             = 1'b1;
                                    mem_waddr          = r_f_idx;
                                    mem_wdata.admitted = ok;
                                    n_valid[r_f_idx]   = 1'b1;
                                    found              = 1'b1;
                                    adm                = ok;
                                    rej                = !ok;
                                    if (ok) begin
                                        n_tot = r_tot + CAP_W'(1);
                                        if (n_tot > r_peak) begin
                                            n_peak = n_tot;
                                        end
                                    end
                                end
                            end
                        end
                        KIND_RESOLVE: begin
                            if (r_p_fnd) begin
                                found = 1'b1;
                                adm   = r_p_adm;
                                if (r_p_adm && r_tot != '0) begin
                                    n_tot = r_tot - CAP_W'(1);
                                end
                                if (r_r_fnd) begin
                                    n_valid[r_p_idx] = 1'b0;
                                end else begin
                                    mem_we             = 1'b1;
                                    mem_waddr          = r_p_idx;
                                    mem_wdata.resolved = 1'b1;
                                    mem_wdata.admitted = r_p_adm;
                                end
                            end else if (r_r_fnd) begin
                                found = 1'b1;
                                adm   = r_r_adm;
                            end
                        end
                        KIND_COMMIT: begin
                            if (r_r_fnd) begin
                                found            = 1'b1;
                                adm              = r_r_adm;
                                n_valid[r_r_idx] = 1'b0;
                            end else if (r_p_fnd) begin
                                found            = 1'b1;
                                adm              = r_p_adm;
                                n_valid[r_p_idx] = 1'b0;
                                if (r_p_adm && r_tot != '0) begin
                                    n_tot = r_tot - CAP_W'(1);
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out_vld  = 1'b1;
                    n_out_data = M_TDATA_W'({n_peak, full,
                        ((r_kind == KIND_SQ_AFTER || r_kind == KIND_SQ_TGT ||
                          r_kind == KIND_CLR_THR) ? rem_sat : CAP_W'(0)),
                        rej, adm, found});
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_m_tvalid  = r_out_vld;
    assign o_m_tdata   = r_out_data;
    assign o_cfg_ready = 1'b1;

endmodule

// ----- hdl/hbat_checker.sv -----
module hbat_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [hbat_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import hbat_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("ready right after an accepted transaction");

    a_reject_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[2] || o_m_tdata[1]) |-> o_m_tdata[0]
            && !(o_m_tdata[2] && o_m_tdata[1]))
        else $error("admitted or rejected without found");

    a_full_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[10] |-> o_m_tdata[2:0] == 3'b000
            && o_m_tdata[9:3] == 7'd0)
        else $error("store full with other flags");

endmodule

bind hard_branch_admission_table hbat_checker u_hbat_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ----- dv/admission_checker.sv -----
module admission_checker #(
    parameter int SLOTS = hbat_pkg::SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [hbat_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic [hbat_pkg::KIND_W-1:0]    i_s_tuser,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [hbat_pkg::M_TDATA_W-1:0] i_m_tdata,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [hbat_pkg::CAP_W-1:0]     i_cfg_data,
    output int                             o_fail_count,
    output int                             o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import hbat_pkg::*;

    // found in bit 0, peak in the top bits, as on the master tdata
    typedef struct packed {
        logic [CAP_W-1:0] peak;
        logic             full;
        logic [CAP_W-1:0] removed;
        logic             rejected;
        logic             admitted;
        logic             found;
    } t_outcome;

    logic             slot_used [SLOTS];
    t_entry           slot      [SLOTS];
    int unsigned      admitted_total;
    int unsigned      peak_total;
    logic [CAP_W-1:0] capacity;
    t_outcome         outcome_q [$];
    int               results_seen;

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
        results_seen  = 0;
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH result %0d: %s got %0h expected %0h", results_seen, what, got,
                 want);
        o_fail_count++;
    endtask

    task automatic check_field(string name, logic [CAP_W-1:0] got, logic [CAP_W-1:0] want);
        if (got !== want) begin
            report_mismatch(name, longint'(got), longint'(want));
        end
    endtask

    function automatic int locate(logic [THR_W-1:0] thr, logic [ID_W-1:0] id,
                                  logic [PC_W-1:0] pc, logic resolved);
        int i;
        for (i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && slot[i].resolved == resolved && slot[i].thread == thr &&
                slot[i].target == id && slot[i].address == pc) begin
                return i;
            end
        end
        return -1;
    endfunction

    // returns 1 when a pending admitted entry goes
    function automatic int unsigned free_slot(int i);
        int unsigned counted;
        counted = 0;
        if (!slot[i].resolved && slot[i].admitted) begin
            if (admitted_total > 0) begin
                admitted_total--;
            end
            counted = 1;
        end
        slot_used[i] = 1'b0;
        return counted;
    endfunction

    function automatic t_outcome admission_outcome(logic [KIND_W-1:0] kind,
                                                   logic [THR_W-1:0] thr,
                                                   logic [ID_W-1:0] id,
                                                   logic [PC_W-1:0] pc);
        t_outcome    o;
        int          p;
        int          r;
        int          i;
        int unsigned removed;
        logic        hit;
        o       = '0;
        removed = 0;
        case (kind)
            KIND_ADD: begin
                if (locate(thr, id, pc, 1'b0) < 0) begin
                    p = -1;
                    for (i = 0; i < SLOTS && p < 0; i++) begin
                        if (!slot_used[i]) begin
                            p = i;
                        end
                    end
                    if (p < 0) begin
                        o.full = 1'b1;
                    end else begin
                        o.found            = 1'b1;
                        o.admitted         = admitted_total < capacity;
                        o.rejected         = !o.admitted;
                        slot_used[p]       = 1'b1;
                        slot[p].resolved   = 1'b0;
                        slot[p].admitted   = o.admitted;
                        slot[p].thread     = thr;
                        slot[p].target     = id;
                        slot[p].address    = pc;
                        if (o.admitted) begin
                            admitted_total++;
                            if (admitted_total > peak_total) begin
                                peak_total = admitted_total;
                            end
                        end
                    end
                end
            end
            KIND_RESOLVE: begin
                p = locate(thr, id, pc, 1'b0);
                if (p >= 0) begin
                    o.found    = 1'b1;
                    o.admitted = slot[p].admitted;
                    if (o.admitted && admitted_total > 0) begin
                        admitted_total--;
                    end
                    // an older resolved twin is kept, the pending copy goes
                    if (locate(thr, id, pc, 1'b1) >= 0) begin
                        slot_used[p] = 1'b0;
                    end else begin
                        slot[p].resolved = 1'b1;
                    end
                end else begin
                    r = locate(thr, id, pc, 1'b1);
                    if (r >= 0) begin
                        o.found    = 1'b1;
                        o.admitted = slot[r].admitted;
                    end
                end
            end
            KIND_COMMIT: begin
                r = locate(thr, id, pc, 1'b1);
                if (r >= 0) begin
                    o.found      = 1'b1;
                    o.admitted   = slot[r].admitted;
                    slot_used[r] = 1'b0;
                end else begin
                    p = locate(thr, id, pc, 1'b0);
                    if (p >= 0) begin
                        o.found    = 1'b1;
                        o.admitted = slot[p].admitted;
                        void'(free_slot(p));
                    end
                end
            end
            KIND_SQ_AFTER, KIND_SQ_TGT, KIND_CLR_THR: begin
                for (i = 0; i < SLOTS; i++) begin
                    if (slot_used[i] && slot[i].thread == thr) begin
                        if (kind == KIND_SQ_AFTER) begin
                            hit = slot[i].target > id;
                        end else if (kind == KIND_SQ_TGT) begin
                            hit = slot[i].target == id && slot[i].address != pc;
                        end else begin
                            hit = 1'b1;
                        end
                        if (hit) begin
                            removed += free_slot(i);
                        end
                    end
                end
                o.removed = CAP_W'(removed);
            end
            default: begin
            end
        endcase
        o.peak = CAP_W'(peak_total);
        return o;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome got;
        int       i;
        if (!i_rst_n) begin
            for (i = 0; i < SLOTS; i++) begin
                slot_used[i] = 1'b0;
            end
            admitted_total = 0;
            peak_total     = 0;
            capacity       = CAP_RST;
            outcome_q.delete();
            o_outstanding <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                capacity = i_cfg_data;
            end
            if (i_m_tvalid && i_m_tready) begin
                got = t_outcome'(i_m_tdata[$bits(t_outcome)-1:0]);
                if (outcome_q.size() == 0) begin
                    report_mismatch("unexpected result", longint'(got), longint'(0));
                end else begin
                    want = outcome_q.pop_front();
                    check_field("found", CAP_W'(got.found), CAP_W'(want.found));
                    check_field("admitted", CAP_W'(got.admitted), CAP_W'(want.admitted));
                    check_field("rejected", CAP_W'(got.rejected), CAP_W'(want.rejected));
                    check_field("removed_count", got.removed, want.removed);
                    check_field("store_full", CAP_W'(got.full), CAP_W'(want.full));
                    check_field("peak_occupancy", got.peak, want.peak);
                end
                results_seen++;
            end
            if (i_s_tvalid && i_s_tready) begin
                outcome_q.push_back(admission_outcome(i_s_tuser,
                                                      i_s_tdata[THR_W-1:0],
                                                      i_s_tdata[THR_W+ID_W-1:THR_W],
                                                      i_s_tdata[THR_W+ID_W+PC_W-1:THR_W+ID_W]));
            end
            o_outstanding <= outcome_q.size();
        end
    end

endmodule

// ----- dv/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hbat_pkg::*;

    localparam int                RANDOM_ITEMS = 780;
    localparam int                POOL_N       = 12;
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [THR_W-1:0] thr;
        logic [ID_W-1:0]  id;
        logic [PC_W-1:0]  pc;
    } t_key;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [KIND_W-1:0]    s_tuser   = '0;
    logic                 m_tready  = 1'b1;
    logic                 cfg_valid = 1'b0;
    logic [CAP_W-1:0]     cfg_data  = '0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_ready;
    int                   fail_count;
    int                   outstanding;

    t_key pool [POOL_N];
    bit   quiet;
    int   ops_sent   = 0;
    int   cfg_writes = 0;
    int   phase      = 0;

    always #10 clk = ~clk;

    hard_branch_admission_table DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    admission_checker u_admission_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding)
    );

    function automatic int unsigned draw_wait();
        if (quiet) begin
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    function automatic logic [PC_W-1:0] random_pc();
        return PC_W'({$urandom(), $urandom()});
    endfunction

    function automatic t_key mk(logic [THR_W-1:0] thr, logic [ID_W-1:0] id,
                                logic [PC_W-1:0] pc);
        t_key k;
        k.thr = thr;
        k.id  = id;
        k.pc  = pc;
        return k;
    endfunction

    task automatic issue_op(logic [KIND_W-1:0] kind, t_key k);
        int unsigned gap;
        gap = draw_wait();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= S_TDATA_W'({k.pc, k.id, k.thr});
        do @(posedge clk); while (!s_tready);
        ops_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // at most two threads and neighboring ids, some keys share an id
    function automatic void refill_pool();
        logic [THR_W-1:0] ta;
        logic [THR_W-1:0] tb;
        logic [ID_W-1:0]  base;
        int               i;
        ta   = THR_W'($urandom_range(0, 7));
        tb   = THR_W'($urandom_range(0, 7));
        base = $urandom();
        for (i = 0; i < POOL_N; i++) begin
            pool[i] = mk($urandom_range(0, 1) ? ta : tb, base + $urandom_range(0, 7),
                         random_pc());
            if (i > 0 && $urandom_range(0, 3) == 0) begin
                pool[i].id = pool[i-1].id;
            end
        end
    endfunction

    task automatic random_op();
        t_key              k;
        int unsigned       r;
        logic [KIND_W-1:0] kind;
        k = pool[$urandom_range(0, POOL_N - 1)];
        if ($urandom_range(0, 9) == 0) begin
            k = mk(THR_W'($urandom_range(0, 7)), $urandom(), random_pc());
        end
        r = $urandom_range(0, 99);
        if (r < 36) begin
            kind = KIND_ADD;
        end else if (r < 56) begin
            kind = KIND_RESOLVE;
        end else if (r < 76) begin
            kind = KIND_COMMIT;
        end else if (r < 84) begin
            kind = KIND_SQ_AFTER;
            k.id = k.id + $urandom_range(0, 4) - 2;
        end else if (r < 91) begin
            kind = KIND_SQ_TGT;
            if ($urandom_range(0, 1) == 0) begin
                k.pc = random_pc();
            end
        end else if (r < 96) begin
            kind = KIND_CLR_THR;
        end else begin
            kind = $urandom_range(0, 1) ? KIND_SPARE_HI : KIND_SPARE_LO;
        end
        issue_op(kind, k);
    endtask

    task automatic fill_store(logic [CAP_W-1:0] cap);
        t_key           filled [SLOTS_DEF + 2];
        logic [ID_W-1:0] base;
        int             i;
        int             pick;
        write_capacity(cap);
        for (i = 0; i < 8; i++) begin
            issue_op(KIND_CLR_THR, mk(THR_W'(i), '0, '0));
        end
        base = $urandom();
        for (i = 0; i < SLOTS_DEF + 2; i++) begin
            filled[i] = mk(THR_W'($urandom_range(0, 7)), base + ID_W'(i), random_pc());
            issue_op(KIND_ADD, filled[i]);
        end
        pick = $urandom_range(0, SLOTS_DEF - 1);
        issue_op(KIND_RESOLVE, filled[pick]);
        // resolved entry still holds its slot
        issue_op(KIND_ADD, filled[SLOTS_DEF]);
        issue_op(KIND_COMMIT, filled[pick]);
        issue_op(KIND_ADD, filled[SLOTS_DEF]);
        issue_op(KIND_SQ_AFTER, mk(filled[0].thr, base + ID_W'(32), '0));
        for (i = 0; i < 8; i++) begin
            issue_op(KIND_CLR_THR, mk(THR_W'(i), '0, '0));
        end
    endtask

    initial begin
        int unsigned stall;
        stall = 0;
        forever begin
            @(posedge clk);
            if (m_tready) begin
                if (m_tvalid) begin
                    stall = draw_wait();
                    if (stall != 0) begin
                        m_tready <= 1'b0;
                    end
                end
            end else if (m_tvalid) begin
                stall--;
                if (stall == 0) begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        t_key             k0;
        t_key             k1;
        t_key             ka;
        t_key             kb;
        t_key             kc;
        t_key             kd;
        t_key             ke;
        logic [PC_W-1:0]  pc_a;
        logic [CAP_W-1:0] cap;
        int               rand_start;
        int               n;
        quiet = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        k0 = mk('0, '0, '0);
        issue_op(KIND_ADD, k0);
        issue_op(KIND_ADD, k0);
        issue_op(KIND_RESOLVE, k0);
        issue_op(KIND_RESOLVE, k0);
        issue_op(KIND_ADD, k0);
        issue_op(KIND_RESOLVE, k0);
        issue_op(KIND_COMMIT, k0);
        issue_op(KIND_COMMIT, k0);

        k1 = mk('1, '1, '1);
        issue_op(KIND_ADD, k1);
        issue_op(KIND_COMMIT, k1);
        issue_op(KIND_RESOLVE, k1);

        pc_a = random_pc();
        ka   = mk(3'd3, 32'd5, pc_a);
        kb   = mk(3'd3, 32'd6, random_pc());
        kc   = mk(3'd3, 32'd5, random_pc());
        kd   = mk(3'd3, '1, pc_a);
        ke   = mk(3'd2, 32'd9, pc_a);
        issue_op(KIND_ADD, ka);
        issue_op(KIND_ADD, kb);
        issue_op(KIND_ADD, kc);
        issue_op(KIND_ADD, kd);
        issue_op(KIND_ADD, ke);
        issue_op(KIND_SQ_AFTER, mk(3'd3, 32'd5, '0));
        issue_op(KIND_SQ_TGT, ka);
        issue_op(KIND_CLR_THR, mk(3'd3, '0, '0));
        issue_op(KIND_CLR_THR, mk(3'd2, '0, '0));
        issue_op(KIND_SPARE_LO, mk(THR_W'($urandom_range(0, 7)), $urandom(), random_pc()));
        issue_op(KIND_SPARE_HI, mk(THR_W'($urandom_range(0, 7)), $urandom(), random_pc()));

        write_capacity('0);
        issue_op(KIND_ADD, ka);
        issue_op(KIND_ADD, kb);
        issue_op(KIND_RESOLVE, ka);
        issue_op(KIND_COMMIT, kb);
        issue_op(KIND_CLR_THR, ka);

        write_capacity(CAP_W'(1));
        issue_op(KIND_ADD, ka);
        issue_op(KIND_ADD, kb);
        issue_op(KIND_COMMIT, ka);
        issue_op(KIND_ADD, kc);
        issue_op(KIND_CLR_THR, ka);

        rand_start = ops_sent;
        while (ops_sent - rand_start < RANDOM_ITEMS) begin
            quiet = ($urandom_range(0, 3) == 0);
            if (phase == 2 || phase == 7) begin
                fill_store(phase == 2 ? CAP_W'(64) : CAP_W'($urandom_range(8, 40)));
            end else begin
                case ($urandom_range(0, 5))
                    0: cap = CAP_W'(64);
                    1: cap = CAP_W'(1);
                    2: cap = '0;
                    default: cap = CAP_W'($urandom_range(1, 64));
                endcase
                write_capacity(cap);
                refill_pool();
                n = $urandom_range(50, 110);
                repeat (n / 2) random_op();
                wait_idle();
                repeat (n - n / 2) random_op();
            end
            phase++;
        end

        wait_idle();
        repeat (80) @(posedge clk);
        $display("Ran %0d operations in %0d random phases with %0d capacity writes.",
                 ops_sent, phase, cfg_writes);
        $display("All kinds, twins, unknown keys, zero/unit/full capacity and full store hit.");
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
